### rtl/utd_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder core.
`timescale 1ns / 1ps

package utd_pkg;

  // Code points and byte classes
  localparam logic [15:0] REPLACEMENT_CHAR = 16'hFFFD;
  localparam logic [7:0]  LEAD2_LOW        = 8'hC2;
  localparam logic [7:0]  LEAD2_HIGH       = 8'hDF;
  localparam logic [7:0]  LEAD3_LOW        = 8'hE0;
  localparam logic [7:0]  LEAD3_HIGH       = 8'hEF;
  localparam logic [7:0]  LEAD3_SURR       = 8'hED;
  localparam logic [7:0]  LEAD4_LOW        = 8'hF0;
  localparam logic [7:0]  LEAD4_HIGH       = 8'hF4;
  localparam logic [7:0]  CONT_LOW         = 8'h80;
  localparam logic [7:0]  CONT_HIGH        = 8'hBF;
  localparam logic [7:0]  E0_CONT_LOW      = 8'hA0;
  localparam logic [7:0]  ED_CONT_HIGH     = 8'h9F;
  localparam logic [7:0]  F0_CONT_LOW      = 8'h90;
  localparam logic [7:0]  F4_CONT_HIGH     = 8'h8F;
  localparam logic [20:0] SUPP_BASE        = 21'h10000;
  localparam logic [15:0] HIGH_SURR_BASE   = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;

  // Pending sequence state
  typedef struct packed {
    logic [14:0] partial_point;
    logic [1:0]  bytes_left;
    logic [7:0]  next_low_bound;
    logic [7:0]  next_high_bound;
  } seq_state_t;

  localparam seq_state_t SEQ_RESET = '{
    partial_point:   15'd0,
    bytes_left:      2'd0,
    next_low_bound:  CONT_LOW,
    next_high_bound: CONT_HIGH
  };

  // One UTF-16 result unit
  typedef struct packed {
    logic [15:0] code_unit;
    logic        replaced;
    logic        run_last;
    logic        text_end;
  } unit_t;

  // All units caused by one input byte
  typedef struct packed {
    unit_t      first;
    unit_t      second;
    logic [1:0] count;
  } step_t;

endpackage

### rtl/utd_decode.sv
// Combinational step logic: one UTF-8 byte against the pending sequence state.
`timescale 1ns / 1ps

module utd_decode import utd_pkg::*; (
  input  logic [7:0] in_byte,
  input  logic       final_byte,
  input  seq_state_t cur,
  output seq_state_t nxt,
  output step_t      step
);

  always_comb begin
    seq_state_t lead_st;
    seq_state_t mid_st;
    logic       lead_emit;
    unit_t      lead_unit;
    logic       cont_ok;
    logic [20:0] cp;
    logic [19:0] offs;
    logic [1:0]  left_dec;
    logic        a_en;
    logic        b_en;
    logic        c_en;
    unit_t       a_unit;
    unit_t       b_unit;
    unit_t       c_unit;
    unit_t       repl_unit;

    repl_unit = '{code_unit: REPLACEMENT_CHAR, replaced: 1'b1,
                  run_last: 1'b0, text_end: 1'b0};

    // Classify the byte as a lead
    lead_st   = SEQ_RESET;
    lead_emit = 1'b0;
    lead_unit = '{code_unit: {8'd0, in_byte}, replaced: 1'b0,
                  run_last: 1'b0, text_end: 1'b0};
    if (!in_byte[7]) begin
      lead_emit = 1'b1;
    end else if (in_byte >= LEAD2_LOW && in_byte <= LEAD2_HIGH) begin
      lead_st.partial_point = {10'd0, in_byte[4:0]};
      lead_st.bytes_left    = 2'd1;
    end else if (in_byte >= LEAD3_LOW && in_byte <= LEAD3_HIGH) begin
      lead_st.partial_point = {11'd0, in_byte[3:0]};
      lead_st.bytes_left    = 2'd2;
      if (in_byte == LEAD3_LOW) lead_st.next_low_bound = E0_CONT_LOW;
      if (in_byte == LEAD3_SURR) lead_st.next_high_bound = ED_CONT_HIGH;
    end else if (in_byte >= LEAD4_LOW && in_byte <= LEAD4_HIGH) begin
      lead_st.partial_point = {12'd0, in_byte[2:0]};
      lead_st.bytes_left    = 2'd3;
      if (in_byte == LEAD4_LOW) lead_st.next_low_bound = F0_CONT_LOW;
      if (in_byte == LEAD4_HIGH) lead_st.next_high_bound = F4_CONT_HIGH;
    end else begin
      lead_emit = 1'b1;
      lead_unit = repl_unit;
    end

    // Continuation path: extend the code point, split into a pair if needed
    cont_ok  = (in_byte >= cur.next_low_bound) && (in_byte <= cur.next_high_bound);
    cp       = {cur.partial_point, in_byte[5:0]};
    offs     = 20'(cp - SUPP_BASE);
    left_dec = cur.bytes_left - 2'd1;

    a_en   = 1'b0;
    b_en   = 1'b0;
    a_unit = repl_unit;
    b_unit = lead_unit;
    mid_st = SEQ_RESET;

    if (cur.bytes_left == 2'd0) begin
      b_en   = lead_emit;
      mid_st = lead_st;
    end else if (cont_ok) begin
      if (left_dec == 2'd0) begin
        a_en = 1'b1;
        if (cp[20:16] != 5'd0) begin
          b_en   = 1'b1;
          a_unit = '{code_unit: HIGH_SURR_BASE + {6'd0, offs[19:10]}, replaced: 1'b0,
                     run_last: 1'b0, text_end: 1'b0};
          b_unit = '{code_unit: LOW_SURR_BASE + {6'd0, offs[9:0]}, replaced: 1'b0,
                     run_last: 1'b0, text_end: 1'b0};
        end else begin
          a_unit = '{code_unit: cp[15:0], replaced: 1'b0,
                     run_last: 1'b0, text_end: 1'b0};
        end
      end else begin
        mid_st.partial_point = cp[14:0];
        mid_st.bytes_left    = left_dec;
      end
    end else begin
      // Drop the cut-short sequence, then re-examine the byte as a lead
      a_en   = 1'b1;
      b_en   = lead_emit;
      mid_st = lead_st;
    end

    // Flush a pending sequence at the end of the text
    c_unit = repl_unit;
    c_en   = final_byte && (mid_st.bytes_left != 2'd0);
    nxt    = final_byte ? SEQ_RESET : mid_st;

    // Pack the enabled units in order
    step.first  = a_en ? a_unit : (b_en ? b_unit : c_unit);
    step.second = a_en ? (b_en ? b_unit : c_unit) : c_unit;
    step.count  = {1'b0, a_en} + {1'b0, b_en} + {1'b0, c_en};

    // Mark the last unit of the byte
    if (step.count == 2'd2) begin
      step.second.run_last = 1'b1;
      step.second.text_end = final_byte;
    end else begin
      step.first.run_last = 1'b1;
      step.first.text_end = final_byte;
    end
  end

endmodule

### rtl/utd_out_buf.sv
// Result register holding the one or two units of a byte and handing them out in order.
`timescale 1ns / 1ps

module utd_out_buf import utd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  step_t       step,
  input  logic        out_stall,
  output logic        out_valid,
  output logic        free,
  output logic [15:0] code_unit,
  output logic        replaced,
  output logic        run_last,
  output logic        text_end
);

  logic  res_valid;
  logic  res_two;
  logic  res_sel;
  unit_t first;
  unit_t second;
  unit_t shown;

  assign shown     = res_sel ? second : first;
  assign out_valid = res_valid;
  assign code_unit = shown.code_unit;
  assign replaced  = shown.replaced;
  assign run_last  = shown.run_last;
  assign text_end  = shown.text_end;

  // Empty, or the last unit leaves this cycle
  assign free = !res_valid || (!out_stall && (!res_two || res_sel));

  // Advance control: load a new item, step to the second unit, or drain
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      res_two   <= 1'b0;
      res_sel   <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
      res_two   <= (step.count == 2'd2);
      res_sel   <= 1'b0;
    end else if (res_valid && !out_stall) begin
      if (res_two && !res_sel) begin
        res_sel <= 1'b1;
      end else begin
        res_valid <= 1'b0;
      end
    end
  end

  // Hold the unit payloads
  always_ff @(posedge clk) begin
    if (load) begin
      first  <= step.first;
      second <= step.second;
    end
  end

endmodule

### rtl/utf8_to_utf16_decoder_core.sv
// An accepted byte is held in the input register and then decoded into the result register.
// Throughput: one byte per cycle while the result register is free; a byte that yields a
// surrogate pair, or a replacement then another unit, holds that register for both units.
// Reset (synchronous, active high) empties both stages and returns the pending
// sequence to none, with the continuation bounds at 0x80..0xBF.
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_core import utd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] code_unit,
  output logic        replaced,
  output logic        run_last,
  output logic        text_end
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_final;
  seq_state_t seq;
  seq_state_t seq_next;
  step_t      step;
  logic       buf_free;
  logic       s1_move;
  logic       in_take;

  // Items with no unit leave without waiting for the result register
  assign s1_move  = s1_valid && ((step.count == 2'd0) || buf_free);
  assign in_stall = s1_valid && !s1_move;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte  <= in_byte;
      s1_final <= final_byte;
    end
  end

  // Sequence state advances as each item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SEQ_RESET;
    end else if (s1_move) begin
      seq <= seq_next;
    end
  end

  utd_decode u_decode (
    .in_byte    (s1_byte),
    .final_byte (s1_final),
    .cur        (seq),
    .nxt        (seq_next),
    .step       (step)
  );

  utd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_move && (step.count != 2'd0)),
    .step      (step),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .free      (buf_free),
    .code_unit (code_unit),
    .replaced  (replaced),
    .run_last  (run_last),
    .text_end  (text_end)
  );

endmodule
